// ----- rtl/dri_pkg.sv -----
// Shared types, widths and helpers for the disparity range inverter.
`default_nettype none

package dri_pkg;

  localparam int COL_W   = 10;
  localparam int DISP_W  = 11;
  localparam int WIDTH_W = 11;
  localparam int STEP_W  = 12;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int MAX_COLS = 1 << COL_W;
  localparam int MAX_DISP = 512;

  localparam logic [ADDR_W-1:0]  ADDR_ROW_WIDTH = ADDR_W'(0);
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST  = WIDTH_W'(MAX_COLS);
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_MAX  = WIDTH_W'(MAX_COLS);

  localparam logic signed [DISP_W-1:0] DISP_HI = DISP_W'(MAX_DISP);
  localparam logic signed [DISP_W-1:0] DISP_LO = -DISP_W'(MAX_DISP);

  typedef struct packed {
    logic                     filled;
    logic signed [DISP_W-1:0] low;
    logic signed [DISP_W-1:0] high;
  } dri_entry_t;

  typedef struct packed {
    logic                     valid;
    logic                     drain;
    logic [COL_W-1:0]         addr;
    logic signed [DISP_W-1:0] nd;
  } dri_wb_t;

  function automatic logic signed [DISP_W-1:0] clamp_disp(
    input logic signed [DISP_W-1:0] v
  );
    logic signed [DISP_W-1:0] r;
    r = v;
    if (v < DISP_LO) r = DISP_LO;
    if (v > DISP_HI) r = DISP_HI;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dri_store.sv -----
// Column store: one write port, one registered read port.
`default_nettype none

module dri_store
  import dri_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [COL_W-1:0] waddr_i,
  input  wire dri_entry_t       wdata_i,
  input  wire logic [COL_W-1:0] raddr_i,
  output dri_entry_t            rdata_o
);

  dri_entry_t mem [MAX_COLS];
  dri_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/dri_fold.sv -----
// Fold unit: merges one negated disparity into a stored column range, or clears the entry on a drain.
`default_nettype none

module dri_fold
  import dri_pkg::*;
(
  input  wire dri_entry_t               rd_i,
  input  wire logic signed [DISP_W-1:0] nd_i,
  input  wire logic                     drain_i,
  output dri_entry_t                    wr_o
);

  always_comb begin
    wr_o = '0;
    if (!drain_i) begin
      wr_o.filled = 1'b1;
      if (!rd_i.filled) begin
        wr_o.low  = nd_i;
        wr_o.high = nd_i;
      end else begin
        wr_o.low  = (nd_i < rd_i.low)  ? nd_i : rd_i.low;
        wr_o.high = (nd_i > rd_i.high) ? nd_i : rd_i.high;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/disparity_range_inverter.sv -----
// Top level: sequencer, config register and result register of the range inverter.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  command  | start, busy            | op, column, range_valid, disp_low, disp_high
//  result   | strobe_o (one cycle)   | out_column, right_low, right_high, right_valid
//  config   | psel/penable/pwrite    | paddr, pwdata, prdata (row_width at 0x0)
//
//  Pixel beat: busy while the right columns are walked; one store
//  read-modify-write per column through the shared fold unit and store port.
//  Invalid pixel beat: busy only in the setup state. Drain beat: busy through
//  the drain state and its store write-back, result registered from the write-back.
//  After reset every store entry is swept clear with busy high; config writes
//  are taken meanwhile. The receiver cannot stall results.
`default_nettype none

module disparity_range_inverter
  import dri_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     op_i,
  input  wire logic [COL_W-1:0]         column_i,
  input  wire logic                     range_valid_i,
  input  wire logic signed [DISP_W-1:0] disp_low_i,
  input  wire logic signed [DISP_W-1:0] disp_high_i,
  output logic                          strobe_o,
  output logic [COL_W-1:0]              out_column_o,
  output logic signed [DISP_W-1:0]      right_low_o,
  output logic signed [DISP_W-1:0]      right_high_o,
  output logic                          right_valid_o,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN
  } state_e;

  state_e                     state_q;
  logic [COL_W-1:0]           clr_cnt_q;
  logic                       valid_q;
  logic [COL_W-1:0]           col_q;
  logic signed [DISP_W-1:0]   lo_q;
  logic signed [DISP_W-1:0]   hi_q;
  logic signed [STEP_W-1:0]   d_q;
  logic signed [STEP_W-1:0]   rc_q;
  dri_wb_t                    wb_q;
  logic                       strobe_q;
  logic [COL_W-1:0]           out_col_q;
  logic signed [DISP_W-1:0]   out_low_q;
  logic signed [DISP_W-1:0]   out_high_q;
  logic                       out_valid_q;
  logic [WIDTH_W-1:0]         row_width_q;

  logic                       accept;
  logic                       cfg_wr;
  logic [WIDTH_W-1:0]         width_eff;
  logic signed [STEP_W-1:0]   lo_ext;
  logic signed [STEP_W-1:0]   hi_ext;
  logic signed [STEP_W-1:0]   neg_col;
  logic signed [STEP_W-1:0]   d_start;
  logic signed [STEP_W-1:0]   rc_start;
  logic                       walk_go;
  logic signed [DISP_W-1:0]   nd;

  logic                       st_we;
  logic [COL_W-1:0]           st_waddr;
  dri_entry_t                 st_wdata;
  logic [COL_W-1:0]           st_raddr;
  dri_entry_t                 st_rdata;
  dri_entry_t                 fold_wr;

  assign busy   = (state_q != ST_IDLE) || wb_q.valid;
  assign accept = start && !busy;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ROW_WIDTH);
  assign prdata = (paddr == ADDR_ROW_WIDTH) ? DATA_W'(row_width_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
    end else if (cfg_wr) begin
      row_width_q <= pwdata[WIDTH_W-1:0];
    end
  end

  assign width_eff = (row_width_q > ROW_WIDTH_MAX) ? ROW_WIDTH_MAX : row_width_q;

  // walk setup and step
  assign lo_ext   = STEP_W'(lo_q);
  assign hi_ext   = STEP_W'(hi_q);
  assign neg_col  = -$signed({2'b00, col_q});
  assign d_start  = (lo_ext > neg_col) ? lo_ext : neg_col;
  assign rc_start = $signed({2'b00, col_q}) + d_start;
  assign walk_go  = (d_q <= hi_ext) && (rc_q < $signed({1'b0, width_eff}));
  assign nd       = DISP_W'(-d_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      valid_q     <= 1'b0;
      col_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      d_q         <= '0;
      rc_q        <= '0;
      wb_q        <= '0;
      strobe_q    <= 1'b0;
      out_col_q   <= '0;
      out_low_q   <= '0;
      out_high_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wb_q.valid <= 1'b0;
      strobe_q   <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + COL_W'(1);
          if (clr_cnt_q == COL_W'(MAX_COLS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            valid_q <= range_valid_i;
            col_q   <= column_i;
            lo_q    <= clamp_disp(disp_low_i);
            hi_q    <= clamp_disp(disp_high_i);
            state_q <= op_i ? ST_DRAIN : ST_SETUP;
          end
        end
        ST_SETUP: begin
          d_q     <= d_start;
          rc_q    <= rc_start;
          state_q <= valid_q ? ST_WALK : ST_IDLE;
        end
        ST_WALK: begin
          if (walk_go) begin
            wb_q <= '{valid: 1'b1, drain: 1'b0, addr: rc_q[COL_W-1:0], nd: nd};
            d_q  <= d_q + STEP_W'(1);
            rc_q <= rc_q + STEP_W'(1);
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_DRAIN: begin
          wb_q    <= '{valid: 1'b1, drain: 1'b1, addr: col_q, nd: '0};
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (wb_q.valid && wb_q.drain) begin
        strobe_q    <= 1'b1;
        out_col_q   <= wb_q.addr;
        out_valid_q <= st_rdata.filled;
        out_low_q   <= st_rdata.filled ? st_rdata.low  : '0;
        out_high_q  <= st_rdata.filled ? st_rdata.high : '0;
      end
    end
  end

  // store port
  assign st_raddr = (state_q == ST_WALK) ? rc_q[COL_W-1:0] : col_q;
  assign st_we    = (state_q == ST_CLEAR) || wb_q.valid;
  assign st_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : wb_q.addr;
  assign st_wdata = (state_q == ST_CLEAR) ? '0 : fold_wr;

  dri_fold u_fold (
    .rd_i    (st_rdata),
    .nd_i    (wb_q.nd),
    .drain_i (wb_q.drain),
    .wr_o    (fold_wr)
  );

  dri_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign strobe_o      = strobe_q;
  assign out_column_o  = out_col_q;
  assign right_low_o   = out_low_q;
  assign right_high_o  = out_high_q;
  assign right_valid_o = out_valid_q;

  a_drain_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i |-> ##3 strobe_o)
    else $error("drain beat gave no result");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("results on consecutive cycles");

  a_no_result_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> !(wb_q.valid && wb_q.drain))
    else $error("drain write-back during column walk");

  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> busy && !strobe_o)
    else $error("activity during store clear");

endmodule

`default_nettype wire

// ----- dv/tb_disparity_range_inverter.sv -----
`timescale 1ns / 1ps
// Self-checking bench for disparity_range_inverter: queued commands, shadow store, APB setup.
module tb_disparity_range_inverter;
  import dri_pkg::*;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e                  op;
    logic [COL_W-1:0]         column;
    logic                     vld;
    logic signed [DISP_W-1:0] lo;
    logic signed [DISP_W-1:0] hi;
  } disp_cmd_t;

  typedef struct packed {
    logic [COL_W-1:0]         column;
    logic signed [DISP_W-1:0] low;
    logic signed [DISP_W-1:0] high;
    logic                     valid;
  } col_range_t;

  localparam int PHASE_CMDS  = 240;
  localparam int N_PHASES    = 7;
  localparam int STALL_LIMIT = 20000;
  localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_W'(4);

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     start         = 1'b0;
  logic                     busy;
  logic                     op_i          = 1'b0;
  logic [COL_W-1:0]         column_i      = '0;
  logic                     range_valid_i = 1'b0;
  logic signed [DISP_W-1:0] disp_low_i    = '0;
  logic signed [DISP_W-1:0] disp_high_i   = '0;
  logic                     strobe_o;
  logic [COL_W-1:0]         out_column_o;
  logic signed [DISP_W-1:0] right_low_o;
  logic signed [DISP_W-1:0] right_high_o;
  logic                     right_valid_o;
  logic                     psel          = 1'b0;
  logic                     penable       = 1'b0;
  logic                     pwrite        = 1'b0;
  logic [ADDR_W-1:0]        paddr         = '0;
  logic [DATA_W-1:0]        pwdata        = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  disp_cmd_t  pending_cmds_q[$];
  col_range_t col_ranges_due_q[$];
  disp_cmd_t  cur_cmd;
  col_range_t due;

  logic [WIDTH_W-1:0] rw_shadow = ROW_WIDTH_RST;
  int col_lo [MAX_COLS];
  int col_hi [MAX_COLS];
  bit col_hit [MAX_COLS];

  int gap_pct   = 0;
  int fail_cnt  = 0;
  int stall_cnt = 0;

  always #2 clk_i = ~clk_i;

  disparity_range_inverter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .column_i      (column_i),
    .range_valid_i (range_valid_i),
    .disp_low_i    (disp_low_i),
    .disp_high_i   (disp_high_i),
    .strobe_o      (strobe_o),
    .out_column_o  (out_column_o),
    .right_low_o   (right_low_o),
    .right_high_o  (right_high_o),
    .right_valid_o (right_valid_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic int bound_disp(input logic signed [DISP_W-1:0] v);
    int r;
    r = v;
    if (r < -MAX_DISP) r = -MAX_DISP;
    if (r > MAX_DISP) r = MAX_DISP;
    return r;
  endfunction

  // fold a pixel range into the shadow store, or read and clear one right column
  function automatic void invert_cmd(input disp_cmd_t c);
    int lo, hi, lim, rc, d;
    col_range_t r;
    if (c.op == OP_DRAIN) begin
      r.column = c.column;
      r.valid  = col_hit[c.column];
      r.low    = '0;
      r.high   = '0;
      if (r.valid) begin
        r.low  = DISP_W'(col_lo[c.column]);
        r.high = DISP_W'(col_hi[c.column]);
      end
      col_hit[c.column] = 1'b0;
      col_ranges_due_q.push_back(r);
    end else if (c.vld) begin
      lo  = bound_disp(c.lo);
      hi  = bound_disp(c.hi);
      lim = (rw_shadow < MAX_COLS) ? int'(rw_shadow) : MAX_COLS;
      for (d = lo; d <= hi; d++) begin
        rc = int'(c.column) + d;
        if (rc >= lim) break;
        if (rc >= 0) begin
          if (!col_hit[rc]) begin
            col_hit[rc] = 1'b1;
            col_lo[rc]  = -d;
            col_hi[rc]  = -d;
          end else begin
            if (-d < col_lo[rc]) col_lo[rc] = -d;
            if (-d > col_hi[rc]) col_hi[rc] = -d;
          end
        end
      end
    end
  endfunction

  function automatic void push_cmd(input cmd_op_e op, input int col, input logic vld,
                                   input int lo, input int hi);
    disp_cmd_t c;
    c.op     = op;
    c.column = COL_W'(col);
    c.vld    = vld;
    c.lo     = DISP_W'(lo);
    c.hi     = DISP_W'(hi);
    pending_cmds_q.push_back(c);
  endfunction

  // mostly bursts of pixels around one band followed by drains over it
  function automatic void queue_traffic(input int n_cmds);
    int goal, lim, b0, kind, k, npix, ndr, col, lo, hi;
    goal = pending_cmds_q.size() + n_cmds;
    lim  = (rw_shadow == 0 || rw_shadow >= MAX_COLS) ? MAX_COLS : int'(rw_shadow);
    while (pending_cmds_q.size() < goal) begin
      kind = $urandom_range(99);
      b0   = $urandom_range(lim - 1);
      if (kind < 70) begin
        npix = $urandom_range(12, 3);
        for (k = 0; k < npix; k++) begin
          col = b0 + int'($urandom_range(40));
          if (col > MAX_COLS - 1) col = MAX_COLS - 1;
          lo = int'($urandom_range(80)) - 40;
          if ($urandom_range(19) == 0) hi = lo - 1 - int'($urandom_range(3));
          else hi = lo + int'($urandom_range(30));
          push_cmd(OP_PIXEL, col, $urandom_range(9) != 0, lo, hi);
        end
        ndr = $urandom_range(16, 4);
        for (k = 0; k < ndr; k++) begin
          col = b0 - 40 + int'($urandom_range(120));
          if (col < 0) col = 0;
          if (col > MAX_COLS - 1) col = MAX_COLS - 1;
          push_cmd(OP_DRAIN, col, 1'($urandom), int'($urandom_range(2047)) - 1024,
                   int'($urandom_range(2047)) - 1024);
        end
      end else if (kind < 97) begin
        push_cmd(cmd_op_e'(1'($urandom)), $urandom_range(MAX_COLS - 1), 1'($urandom),
                 int'($urandom_range(2047)) - 1024, int'($urandom_range(2047)) - 1024);
      end else begin
        push_cmd(OP_PIXEL, $urandom_range(MAX_COLS - 1), 1'b1,
                 -int'($urandom_range(560)), int'($urandom_range(560)));
      end
    end
  endfunction

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && addr == ADDR_ROW_WIDTH) rw_shadow = wdata[WIDTH_W-1:0];
  endtask

  task automatic program_width(input int w);
    logic [DATA_W-1:0] rd;
    apb_access(1'b1, ADDR_ROW_WIDTH, DATA_W'(w), rd);
    apb_access(1'b0, ADDR_ROW_WIDTH, '0, rd);
    if (rd !== DATA_W'(rw_shadow))
      note_fail($sformatf("row_width reads %0d, wrote %0d", rd, rw_shadow));
  endtask

  // sampled on the falling edge so driver and monitor updates have settled
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (pending_cmds_q.size() != 0 || start || col_ranges_due_q.size() != 0 || busy);
    repeat (8) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) invert_cmd(cur_cmd);
      if (!start || !busy) begin
        if (pending_cmds_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          cur_cmd = pending_cmds_q.pop_front();
          start         <= 1'b1;
          op_i          <= cur_cmd.op;
          column_i      <= cur_cmd.column;
          range_valid_i <= cur_cmd.vld;
          disp_low_i    <= cur_cmd.lo;
          disp_high_i   <= cur_cmd.hi;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (col_ranges_due_q.size() == 0) begin
        note_fail($sformatf("result beat for column %0d with none due", out_column_o));
      end else begin
        due = col_ranges_due_q.pop_front();
        if (out_column_o !== due.column || right_low_o !== due.low ||
            right_high_o !== due.high || right_valid_o !== due.valid)
          note_fail($sformatf(
            "exp col %0d lo %0d hi %0d vld %0b, got col %0d lo %0d hi %0d vld %0b",
            due.column, due.low, due.high, due.valid,
            out_column_o, right_low_o, right_high_o, right_valid_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || strobe_o || (psel && penable && pready)) begin
        stall_cnt <= 0;
      end else if (stall_cnt >= STALL_LIMIT) begin
        $display("FAIL disparity_range_inverter");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] rd;
    int ph;
    int w;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    apb_access(1'b0, ADDR_ROW_WIDTH, '0, rd);
    if (rd !== DATA_W'(ROW_WIDTH_RST))
      note_fail($sformatf("row_width after reset reads %0d", rd));

    // directed: unreached drain, edge columns, invalid, empty and clamped ranges
    push_cmd(OP_DRAIN, 5, 1'b0, 0, 0);
    push_cmd(OP_PIXEL, 0, 1'b1, -3, 3);
    push_cmd(OP_PIXEL, MAX_COLS - 1, 1'b1, -2, 5);
    push_cmd(OP_PIXEL, 10, 1'b0, 0, 5);
    push_cmd(OP_PIXEL, 20, 1'b1, 5, 2);
    push_cmd(OP_PIXEL, 100, 1'b1, -1024, 1023);
    push_cmd(OP_PIXEL, 600, 1'b1, -1024, -700);
    push_cmd(OP_PIXEL, 300, 1'b1, 700, 1000);
    push_cmd(OP_PIXEL, 810, 1'b1, 0, 4);
    push_cmd(OP_DRAIN, 0, 1'b1, 0, 0);
    push_cmd(OP_DRAIN, 3, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 1021, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, MAX_COLS - 1, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 10, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 20, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 88, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 612, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 613, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 812, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 812, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 814, 1'b0, 0, 0);
    push_cmd(OP_DRAIN, 5, 1'b0, 0, 0);
    wait_quiet();

    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph % 3)
        0: gap_pct = 0;
        1: gap_pct = 61;
        default: gap_pct = 13;
      endcase
      case (ph)
        0: w = 1;
        1: w = 2047;
        2: w = 0;
        4: w = MAX_COLS;
        6: w = MAX_COLS - 1;
        default: w = $urandom_range(MAX_COLS - 1, 2);
      endcase
      if (ph == 2) apb_access(1'b1, ADDR_SPARE, DATA_W'($urandom), rd);
      program_width(w);
      queue_traffic(PHASE_CMDS);
      wait_quiet();
    end

    if (col_ranges_due_q.size() != 0)
      note_fail($sformatf("%0d result beats never arrived", col_ranges_due_q.size()));
    if (fail_cnt == 0) begin
      $display("PASS disparity_range_inverter");
    end else begin
      $display("FAIL disparity_range_inverter");
    end
    $finish;
  end

endmodule
